[design/rect_polar_converter_core_assert.svh]
// Assertion macros shared by the converter modules
`ifndef RECT_POLAR_CONVERTER_CORE_ASSERT_SVH
`define RECT_POLAR_CONVERTER_CORE_ASSERT_SVH

// Implication checked on every rising clock edge outside reset
`define RPC_ASSERT_IMPL(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed");

// Next-cycle implication checked outside reset
`define RPC_ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");

`endif

[design/rpc_pkg.sv]
// Package: shared types and constants for the rectangular/polar converter
`default_nettype none
package rpc_pkg;
    localparam int GUARD  = 14;
    localparam int CW     = 42;   // coordinate datapath width
    localparam int ZW     = 32;   // angle datapath width
    localparam int MAXMAG = 46341;
    localparam logic [23:0] INVK = 24'd10188014;
    localparam logic signed [ZW-1:0] DEG90  = 32'sd94371840;
    localparam logic signed [ZW-1:0] DEG180 = 32'sd188743680;

    typedef enum logic {
        t_mode_polar = 1'b0,
        t_mode_rect  = 1'b1
    } t_mode;

    // Item handed from the front to the back part
    typedef struct packed {
        logic                   mode;
        logic                   zero;
        logic signed [CW-1:0]   x;
        logic signed [CW-1:0]   y;
        logic signed [ZW-1:0]   z;
    } t_work;

    function automatic logic signed [ZW-1:0] atan_deg(input int i);
        logic signed [ZW-1:0] t;
        begin
            case (i)
                0: t = 32'sd47185920;  1: t = 32'sd27855475;
                2: t = 32'sd14718068;  3: t = 32'sd7471121;
                4: t = 32'sd3750058;   5: t = 32'sd1876857;
                6: t = 32'sd938658;    7: t = 32'sd469357;
                8: t = 32'sd234682;    9: t = 32'sd117342;
                10: t = 32'sd58671;    11: t = 32'sd29335;
                12: t = 32'sd14668;    13: t = 32'sd7334;
                14: t = 32'sd3667;     15: t = 32'sd1833;
                16: t = 32'sd917;      17: t = 32'sd458;
                18: t = 32'sd229;      19: t = 32'sd115;
                20: t = 32'sd57;       21: t = 32'sd29;
                22: t = 32'sd14;       23: t = 32'sd7;
                default: t = '0;
            endcase
            return t;
        end
    endfunction
endpackage
`default_nettype wire

[design/rpc_if.sv]
// Valid/ready channel interfaces for input and result transactions
`default_nettype none
interface rpc_in_if;
    logic               valid;
    logic               ready;
    logic               func;
    logic signed [15:0] x_in;
    logic signed [15:0] y_in;
    logic [15:0]        mag_in;
    logic signed [15:0] angle_in;
    modport source (output valid, func, x_in, y_in, mag_in, angle_in, input ready);
    modport sink   (input valid, func, x_in, y_in, mag_in, angle_in, output ready);
endinterface

interface rpc_out_if;
    logic               valid;
    logic               ready;
    logic [15:0]        mag_out;
    logic signed [15:0] angle_out;
    logic signed [16:0] x_out;
    logic signed [16:0] y_out;
    modport source (output valid, mag_out, angle_out, x_out, y_out, input ready);
    modport sink   (input valid, mag_out, angle_out, x_out, y_out, output ready);
endinterface
`default_nettype wire

[design/rpc_front.sv]
// Front part: accepts transactions, classifies the mode and sets up CORDIC start values
`default_nettype none
module rpc_front (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    rpc_in_if.sink          in_ch,
    input  wire logic       i_ready,
    output rpc_pkg::t_work  o_work,
    output logic            o_valid
);
    rpc_pkg::t_work r_work, n_work;
    logic r_valid;
    logic signed [rpc_pkg::CW-1:0] xs, ys;
    logic [15:0] m;
    logic signed [16:0] a;
    logic signed [rpc_pkg::ZW-1:0] z;
    logic [39:0] mk;

    assign in_ch.ready = !r_valid || i_ready;
    assign o_work  = r_work;
    assign o_valid = r_valid;

    // Start values for both conversion directions
    always_comb begin
        xs = rpc_pkg::CW'(in_ch.x_in) <<< rpc_pkg::GUARD;
        ys = rpc_pkg::CW'(in_ch.y_in) <<< rpc_pkg::GUARD;
        m  = (in_ch.mag_in > 16'(rpc_pkg::MAXMAG)) ? 16'(rpc_pkg::MAXMAG) : in_ch.mag_in;
        a  = 17'(in_ch.angle_in);
        if (a > 17'sd23040)       a = a - 17'sd46080;
        else if (a < -17'sd23040) a = a + 17'sd46080;
        z  = rpc_pkg::ZW'(a) <<< 13;
        mk = (40'(m) * 40'(rpc_pkg::INVK) + 40'd512) >> 10;
        n_work = '0;
        n_work.mode = in_ch.func;
        if (in_ch.func == rpc_pkg::t_mode_rect) begin
            n_work.x = rpc_pkg::CW'(mk);
            n_work.z = z;
            if (z > rpc_pkg::DEG90) begin
                n_work.x = -rpc_pkg::CW'(mk);
                n_work.z = z - rpc_pkg::DEG180;
            end else if (z < -rpc_pkg::DEG90) begin
                n_work.x = -rpc_pkg::CW'(mk);
                n_work.z = z + rpc_pkg::DEG180;
            end
        end else begin
            n_work.zero = (in_ch.x_in == 16'sd0) && (in_ch.y_in == 16'sd0);
            n_work.x = xs;
            n_work.y = ys;
            if (xs < 0) begin
                n_work.z = (ys >= 0) ? rpc_pkg::DEG180 : -rpc_pkg::DEG180;
                n_work.x = -xs;
                n_work.y = -ys;
            end
        end
    end

    // Stage register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (in_ch.ready) begin
            r_valid <= in_ch.valid;
        end
        if (in_ch.ready && in_ch.valid) begin
            r_work <= n_work;
        end
    end
endmodule
`default_nettype wire

[design/rpc_queue.sv]
// Two-entry queue between the front and the back part
`default_nettype none
module rpc_queue (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_ready,
    input  rpc_pkg::t_work  i_work,
    output logic            o_valid,
    input  wire logic       i_ready,
    output rpc_pkg::t_work  o_work
);
    `include "rect_polar_converter_core_assert.svh"
    rpc_pkg::t_work r_mem [2];
    logic r_wp, r_rp;
    logic [1:0] r_cnt;
    logic push, pop;

    assign o_ready = r_cnt != 2'd2;
    assign o_valid = r_cnt != 2'd0;
    assign push = i_valid && o_ready;
    assign pop  = o_valid && i_ready;
    assign o_work = r_mem[r_rp];

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= !r_wp;
            if (pop)  r_rp <= !r_rp;
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
    end

    // Storage
    always_ff @(posedge i_clk) begin
        if (push) r_mem[r_wp] <= i_work;
    end

    `RPC_ASSERT_IMPL(a_cnt_range, i_clk, i_rst_n, 1'b1, r_cnt != 2'd3)
    `RPC_ASSERT_NEXT(a_full_holds, i_clk, i_rst_n, (r_cnt == 2'd2) && !pop, r_cnt == 2'd2)
    `RPC_ASSERT_IMPL(a_ptr_match, i_clk, i_rst_n, r_cnt == 2'd0 || r_cnt == 2'd2, r_wp == r_rp)
endmodule
`default_nettype wire

[design/rpc_back.sv]
// Back part: pipelined CORDIC stages, gain removal, rounding and output register
`default_nettype none
module rpc_back #(
    parameter int ITERATIONS = 16
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_ready,
    input  rpc_pkg::t_work  i_work,
    rpc_out_if.source       out_ch
);
    `include "rect_polar_converter_core_assert.svh"
    localparam int N = ITERATIONS;
    rpc_pkg::t_work r_st [N+1];
    logic [N+1:0] r_v;
    logic [N+1:0] adv;
    logic signed [65:0] r_prod;
    logic r_pmode, r_pzero;
    logic signed [rpc_pkg::CW-1:0] r_px, r_py;
    logic signed [rpc_pkg::ZW-1:0] r_pz;
    logic r_ov;
    logic [15:0] r_mag;
    logic signed [15:0] r_ang;
    logic signed [16:0] r_xo, r_yo;
    logic signed [65:0] mg;
    logic signed [rpc_pkg::ZW-1:0] ag;
    logic signed [rpc_pkg::CW-1:0] xr, yr;
    logic [15:0] n_mag;
    logic signed [15:0] n_ang;
    logic signed [16:0] n_xo, n_yo;

    // Stall chain: a stage moves when it is empty or the next one moves
    always_comb begin
        adv[N+1] = !r_ov || out_ch.ready;
        for (int k = N; k >= 0; k--) adv[k] = !r_v[k] || adv[k+1];
    end
    assign o_ready = adv[0];

    // Stage 0 latches the queue head; stages 1..N are micro-rotations
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (adv[0]) r_v[0] <= i_valid;
            for (int k = 1; k <= N; k++) if (adv[k]) r_v[k] <= r_v[k-1];
            if (adv[N+1]) r_v[N+1] <= r_v[N];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv[0] && i_valid) r_st[0] <= i_work;
    end

    for (genvar g = 0; g < N; g++) begin : g_rot
        logic d;
        rpc_pkg::t_work w, n;
        always_comb begin
            w = r_st[g];
            n = w;
            d = (w.mode == rpc_pkg::t_mode_rect) ? (w.z >= 0) : (w.y >= 0);
            if (w.mode == rpc_pkg::t_mode_rect) d = !d;
            // d high means rotate clockwise (x + y>>i)
            if (d) begin
                n.x = w.x + (w.y >>> g);
                n.y = w.y - (w.x >>> g);
                n.z = w.z + rpc_pkg::atan_deg(g);
            end else begin
                n.x = w.x - (w.y >>> g);
                n.y = w.y + (w.x >>> g);
                n.z = w.z - rpc_pkg::atan_deg(g);
            end
            if (w.mode == rpc_pkg::t_mode_rect) begin
                n.z = d ? w.z + rpc_pkg::atan_deg(g) : w.z - rpc_pkg::atan_deg(g);
            end
        end
        always_ff @(posedge i_clk) begin
            if (adv[g+1] && r_v[g]) r_st[g+1] <= n;
        end
    end

    // Gain multiply stage
    always_ff @(posedge i_clk) begin
        if (adv[N+1] && r_v[N]) begin
            r_prod  <= 66'(r_st[N].x) * $signed({1'b0, rpc_pkg::INVK});
            r_pmode <= r_st[N].mode;
            r_pzero <= r_st[N].zero;
            r_px    <= r_st[N].x;
            r_py    <= r_st[N].y;
            r_pz    <= r_st[N].z;
        end
    end

    // Rounding and saturation
    always_comb begin
        mg = (r_prod + (66'sd1 <<< 37)) >>> 38;
        ag = (r_pz + (32'sd1 <<< 12)) >>> 13;
        xr = (r_px + (42'sd1 <<< 13)) >>> 14;
        yr = (r_py + (42'sd1 <<< 13)) >>> 14;
        n_mag = '0; n_ang = '0; n_xo = '0; n_yo = '0;
        if (r_pmode == rpc_pkg::t_mode_rect) begin
            n_xo = (xr > 42'sd46341) ? 17'sd46341 : (xr < -42'sd46341) ? -17'sd46341 : 17'(xr);
            n_yo = (yr > 42'sd46341) ? 17'sd46341 : (yr < -42'sd46341) ? -17'sd46341 : 17'(yr);
        end else if (!r_pzero) begin
            n_mag = (mg > 66'sd46341) ? 16'd46341 : (mg < 0) ? 16'd0 : 16'(mg);
            n_ang = (ag > 32'sd23040) ? 16'sd23040 : (ag < -32'sd23040) ? -16'sd23040 : 16'(ag);
        end
    end

    // Output register
    logic r_pv;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            if (adv[N+1]) r_pv <= r_v[N];
            if (!r_ov || out_ch.ready) r_ov <= r_v[N+1];
        end
        if ((!r_ov || out_ch.ready) && r_v[N+1]) begin
            r_mag <= n_mag; r_ang <= n_ang; r_xo <= n_xo; r_yo <= n_yo;
        end
    end

    assign out_ch.valid     = r_ov;
    assign out_ch.mag_out   = r_mag;
    assign out_ch.angle_out = r_ang;
    assign out_ch.x_out     = r_xo;
    assign out_ch.y_out     = r_yo;

    `RPC_ASSERT_IMPL(a_pv_match, i_clk, i_rst_n, 1'b1, r_pv == r_v[N+1])
    `RPC_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, r_ov && !out_ch.ready, r_ov && $stable(r_mag))
    `RPC_ASSERT_IMPL(a_mode_excl, i_clk, i_rst_n, r_ov, r_mag == 16'd0 || r_xo == 17'sd0)
endmodule
`default_nettype wire

[design/rect_polar_converter_core.sv]
// Top level of the CORDIC rectangular/polar converter
//  channel | dir | fields                               | handshake
//  in_ch   | in  | func, x_in, y_in, mag_in, angle_in   | valid/ready
//  out_ch  | out | mag_out, angle_out, x_out, y_out     | valid/ready
// One transaction per cycle sustained while out_ch is not stalled. Each passes through the
// setup register, queue, stage 0, micro-rotation stages, gain and output registers.
// Synchronous active-low reset empties all stages and the queue.
// An output stall backs up through the stages, then the queue, then the front.
`default_nettype none
module rect_polar_converter_core #(
    parameter int ITERATIONS = 16
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    rpc_in_if.sink    in_ch,
    rpc_out_if.source out_ch
);
    rpc_pkg::t_work f_work, q_work;
    logic f_valid, f_ready, q_valid, q_ready;

    rpc_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .in_ch(in_ch),
        .i_ready(f_ready), .o_work(f_work), .o_valid(f_valid)
    );

    rpc_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(f_valid), .o_ready(f_ready), .i_work(f_work),
        .o_valid(q_valid), .i_ready(q_ready), .o_work(q_work)
    );

    rpc_back #(.ITERATIONS(ITERATIONS)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(q_valid), .o_ready(q_ready), .i_work(q_work), .out_ch(out_ch)
    );
endmodule
`default_nettype wire
